>>> design/rpsga_pkg.sv
// Shared types, codes and helpers for the rock-paper-scissors grid automaton.
// No dependencies; all files of the block but the interface and the RAM import this package.
`timescale 1ns / 1ps

package rpsga_pkg;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_RUN   = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [1:0] CELL_ROCK     = 2'd0;
	localparam logic [1:0] CELL_PAPER    = 2'd1;
	localparam logic [1:0] CELL_SCISSORS = 2'd2;
	localparam logic [1:0] CELL_INERT    = 2'd3;

	localparam logic [1:0] CFG_ROWS = 2'd0;
	localparam logic [1:0] CFG_COLS = 2'd1;
	localparam logic [1:0] CFG_GENS = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [6:0] row;
		logic [6:0] col;
		logic [1:0] value;
	} rpsga_item_t;

	typedef struct packed {
		logic [1:0] cell_res;
		logic       done_res;
	} rpsga_res_t;

	typedef struct packed {
		logic [1:0] index;
		logic [9:0] value;
	} rpsga_cfg_t;

	typedef struct packed {
		logic active;
		logic col_in;
		logic dn_ok;
		logic up_ok;
		logic lf_ok;
		logic emit;
	} rpsga_scan_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_RUN,
		ST_GAP,
		ST_FINISH
	} rpsga_state_t;

	function automatic logic [1:0] beater_of(input logic [1:0] v);
		logic [1:0] b;
		case (v)
			CELL_ROCK:     b = CELL_PAPER;
			CELL_PAPER:    b = CELL_SCISSORS;
			CELL_SCISSORS: b = CELL_ROCK;
			default:       b = CELL_INERT;
		endcase
		return b;
	endfunction

endpackage

>>> design/rpsga_chan_if.sv
// Valid/ready channel interface with a typed payload.
// Used for the item, result and configuration channels; payload types come from rpsga_pkg.
`timescale 1ns / 1ps

interface rpsga_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/rps_grid_automaton_top.sv
// Top level of the rock-paper-scissors grid automaton: grid RAM, sequencer and update stage.
// Depends on rpsga_pkg, rpsga_chan_if, rpsga_ram, rpsga_upd and rpsga_ctrl.
//
// Channel  | Direction | Payload                      | Beat
// ---------+-----------+------------------------------+----------------------------------
// item     | in        | mode, row, col, value        | one command
// result   | out       | cell_res, done_res           | one completion per command
// cfg      | in        | index (2 bits), value (10)   | one register write, always ready
//
// A write goes from IDLE to FINISH; a read goes via READ, which takes the registered RAM data.
// A run scans rows 0 to rows and columns 0 to cols once per generation: the grid RAM
// is read and written back once per cell per generation, one cell a cycle.
// Commands are taken one at a time; a stalled result holds the next command in its last cycle.
// Reset sets 1 row, 1 column, 0 generations and idle control; grid is undefined until written.
`timescale 1ns / 1ps

module rps_grid_automaton_top #(
	parameter int MAX_ROWS = 128,
	parameter int MAX_COLS = 128
) (
	input logic          clk,
	input logic          arst_n,
	rpsga_chan_if.sink   item,
	rpsga_chan_if.source result,
	rpsga_chan_if.sink   cfg
);
	import rpsga_pkg::*;

	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int AW    = RW + CW;
	localparam int DEPTH = MAX_ROWS * (2 ** CW);

	rpsga_scan_t   scan;
	logic [CW-1:0] lb_addr;
	logic [AW-1:0] wr_addr;
	logic          main_re;
	logic [AW-1:0] main_raddr;
	logic [1:0]    main_rdata;
	logic          item_we;
	logic [AW-1:0] item_waddr;
	logic [1:0]    item_wdata;
	logic          upd_we;
	logic [AW-1:0] upd_waddr;
	logic [1:0]    upd_wdata;
	logic          main_we;
	logic [AW-1:0] main_waddr;
	logic [1:0]    main_wdata;

	rpsga_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.result     (result),
		.cfg        (cfg),
		.main_re    (main_re),
		.main_raddr (main_raddr),
		.main_rdata (main_rdata),
		.item_we    (item_we),
		.item_waddr (item_waddr),
		.item_wdata (item_wdata),
		.scan       (scan),
		.lb_addr    (lb_addr),
		.wr_addr    (wr_addr)
	);

	rpsga_upd #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_upd (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan       (scan),
		.lb_addr    (lb_addr),
		.wr_addr    (wr_addr),
		.main_rdata (main_rdata),
		.main_we    (upd_we),
		.main_waddr (upd_waddr),
		.main_wdata (upd_wdata)
	);

	assign main_we    = upd_we || item_we;
	assign main_waddr = upd_we ? upd_waddr : item_waddr;
	assign main_wdata = upd_we ? upd_wdata : item_wdata;

	rpsga_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_grid (
		.clk   (clk),
		.we    (main_we),
		.waddr (main_waddr),
		.wdata (main_wdata),
		.re    (main_re),
		.raddr (main_raddr),
		.rdata (main_rdata)
	);

endmodule

>>> design/rpsga_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rpsga_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/rpsga_upd.sv
// Cell update stage: two line buffers, a neighbor window and the beater rule.
// Depends on rpsga_pkg and rpsga_ram; fed by the scan sequence of rpsga_ctrl.
`timescale 1ns / 1ps

module rpsga_upd #(
	parameter int MAX_ROWS = 128,
	parameter int MAX_COLS = 128,
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int AW = RW + CW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rpsga_pkg::rpsga_scan_t scan,
	input  logic [CW-1:0]         lb_addr,
	input  logic [AW-1:0]         wr_addr,
	input  logic [1:0]            main_rdata,
	output logic                  main_we,
	output logic [AW-1:0]         main_waddr,
	output logic [1:0]            main_wdata
);
	import rpsga_pkg::*;

	rpsga_scan_t   scan_s1;
	logic [CW-1:0] lb_addr_s1;
	logic [AW-1:0] wr_addr_s1;
	logic [1:0]    cur_rd;
	logic [1:0]    prev_rd;
	logic [1:0]    ctr_q;
	logic [1:0]    up_q;
	logic [1:0]    dn_q;
	logic [1:0]    lf_q;
	logic [1:0]    beat;
	logic          hit;
	logic          lb_re;
	logic          lb_we;

	assign lb_re = scan.active && scan.col_in;
	assign lb_we = scan_s1.active && scan_s1.col_in;

	// The current buffer holds the old row above the one being read from the grid,
	// the previous buffer the old row above that.
	rpsga_ram #(.WIDTH(2), .DEPTH(MAX_COLS)) u_cur_lb (
		.clk   (clk),
		.we    (lb_we),
		.waddr (lb_addr_s1),
		.wdata (main_rdata),
		.re    (lb_re),
		.raddr (lb_addr),
		.rdata (cur_rd)
	);

	rpsga_ram #(.WIDTH(2), .DEPTH(MAX_COLS)) u_prev_lb (
		.clk   (clk),
		.we    (lb_we),
		.waddr (lb_addr_s1),
		.wdata (cur_rd),
		.re    (lb_re),
		.raddr (lb_addr),
		.rdata (prev_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= '0;
		end else begin
			scan_s1 <= scan;
		end
	end

	always_ff @(posedge clk) begin
		lb_addr_s1 <= lb_addr;
		wr_addr_s1 <= wr_addr;
		if (scan_s1.active) begin
			ctr_q <= cur_rd;
			up_q  <= prev_rd;
			dn_q  <= main_rdata;
			lf_q  <= ctr_q;
		end
	end

	always_comb begin
		beat = beater_of(ctr_q);
		hit  = (beat != CELL_INERT) &&
			((scan_s1.up_ok && (up_q == beat)) ||
			 (scan_s1.dn_ok && (dn_q == beat)) ||
			 (scan_s1.lf_ok && (lf_q == beat)) ||
			 (scan_s1.col_in && (cur_rd == beat)));
	end

	assign main_we    = scan_s1.active && scan_s1.emit;
	assign main_waddr = wr_addr_s1;
	assign main_wdata = hit ? beat : ctr_q;

endmodule

>>> design/rpsga_ctrl.sv
// Sequencer: configuration registers, item handling, grid scan counters and result register.
// Depends on rpsga_pkg and rpsga_chan_if.
`timescale 1ns / 1ps

module rpsga_ctrl #(
	parameter int MAX_ROWS = 128,
	parameter int MAX_COLS = 128,
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int AW = RW + CW
) (
	input  logic                   clk,
	input  logic                   arst_n,
	rpsga_chan_if.sink             item,
	rpsga_chan_if.source           result,
	rpsga_chan_if.sink             cfg,
	output logic                   main_re,
	output logic [AW-1:0]          main_raddr,
	input  logic [1:0]             main_rdata,
	output logic                   item_we,
	output logic [AW-1:0]          item_waddr,
	output logic [1:0]             item_wdata,
	output rpsga_pkg::rpsga_scan_t scan,
	output logic [CW-1:0]          lb_addr,
	output logic [AW-1:0]          wr_addr
);
	import rpsga_pkg::*;

	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CCW = $clog2(MAX_COLS + 1);

	rpsga_state_t   state_q;
	rpsga_state_t   state_d;
	logic [7:0]     rows_q;
	logic [7:0]     cols_q;
	logic [9:0]     gens_q;
	logic [RCW-1:0] nr;
	logic [CCW-1:0] nc;
	logic [RCW-1:0] rr_q;
	logic [CCW-1:0] y_q;
	logic [9:0]     gen_q;
	logic           rd_ok_q;
	logic [1:0]     cell_q;
	logic           out_valid_q;
	logic [1:0]     out_cell_q;
	logic           item_hs;
	logic           in_range;
	logic [AW-1:0]  item_addr;
	logic [AW-1:0]  run_addr;
	logic           run_zero;
	logic           last_col;
	logic           last_row;
	logic           last_gen;
	logic           load;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 8'd1;
			cols_q <= 8'd1;
			gens_q <= 10'd0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				CFG_ROWS: rows_q <= cfg.data.value[7:0];
				CFG_COLS: cols_q <= cfg.data.value[7:0];
				CFG_GENS: gens_q <= cfg.data.value;
				default: ;
			endcase
		end
	end

	assign nr = (32'(rows_q) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_q);
	assign nc = (32'(cols_q) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_q);

	assign item_hs   = item.valid && item.ready;
	assign in_range  = (32'(item.data.row) < MAX_ROWS) && (32'(item.data.col) < MAX_COLS);
	assign item_addr = {RW'(item.data.row), CW'(item.data.col)};
	assign run_addr  = {RW'(rr_q), CW'(y_q)};
	assign run_zero  = (nr == '0) || (nc == '0) || (gens_q == 10'd0);
	assign last_col  = (y_q == nc);
	assign last_row  = (rr_q == nr);
	assign last_gen  = (gen_q == gens_q - 10'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		load       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					case (item.data.mode)
						MODE_WRITE: state_d = ST_FINISH;
						MODE_READ:  state_d = ST_READ;
						MODE_RUN:   state_d = run_zero ? ST_FINISH : ST_RUN;
						default:    state_d = ST_FINISH;
					endcase
				end
			end
			ST_READ: state_d = ST_FINISH;
			ST_RUN: begin
				if (last_col && last_row) begin
					state_d = ST_GAP;
				end
			end
			ST_GAP: state_d = last_gen ? ST_FINISH : ST_RUN;
			ST_FINISH: begin
				load = !out_valid_q || result.ready;
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q  <= '0;
			y_q   <= '0;
			gen_q <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (last_col) begin
						y_q <= '0;
						if (!last_row) begin
							rr_q <= rr_q + 1'b1;
						end
					end else begin
						y_q <= y_q + 1'b1;
					end
				end
				ST_GAP: begin
					rr_q  <= '0;
					y_q   <= '0;
					gen_q <= gen_q + 10'd1;
				end
				default: begin
					rr_q  <= '0;
					y_q   <= '0;
					gen_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_hs) begin
			rd_ok_q <= in_range;
			cell_q  <= CELL_ROCK;
		end else if (state_q == ST_READ) begin
			cell_q <= rd_ok_q ? main_rdata : CELL_ROCK;
		end
		if (load) begin
			out_cell_q <= cell_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.data.cell_res = out_cell_q;
	assign result.data.done_res = 1'b1;

	assign item_we    = item_hs && (item.data.mode == MODE_WRITE) && in_range;
	assign item_waddr = item_addr;
	assign item_wdata = item.data.value;

	always_comb begin
		if (state_q == ST_RUN) begin
			main_re    = (rr_q < nr) && (y_q < nc);
			main_raddr = run_addr;
		end else begin
			main_re    = item_hs && (item.data.mode == MODE_READ) && in_range;
			main_raddr = item_addr;
		end
	end

	always_comb begin
		scan.active = (state_q == ST_RUN);
		scan.col_in = (y_q < nc);
		scan.dn_ok  = (rr_q < nr);
		scan.up_ok  = (32'(rr_q) >= 2);
		scan.lf_ok  = (32'(y_q) >= 2);
		scan.emit   = (rr_q != '0) && (y_q != '0);
	end

	assign lb_addr = CW'(y_q);
	assign wr_addr = {RW'(rr_q - 1'b1), CW'(y_q - 1'b1)};

endmodule

>>> design/rpsga_chk.sv
// Port-level checker for the grid automaton, attached to the top level by a bind.
// Depends on rpsga_pkg.
`timescale 1ns / 1ps

module rpsga_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_ready,
	input logic [1:0]           item_mode,
	input logic                 res_valid,
	input logic                 res_ready,
	input rpsga_pkg::rpsga_res_t res_data
);
	import rpsga_pkg::*;

	// A result that is not taken stays on the port unchanged.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result beat changed while stalled");

	// Every result reports completion.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.done_res)
		else $error("result without done flag");

	// Commands are handled one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("command taken while another is in flight");

	// A cell write with a free result register completes through FINISH, which loads the result.
	a_write_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_mode == MODE_WRITE) && !res_valid
		|=> ##1 res_valid)
		else $error("cell write result late");

endmodule

bind rps_grid_automaton_top rpsga_chk u_rpsga_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.item_mode  (item.data.mode),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_data   (result.data)
);

>>> sim/tb_rpsga_checker.sv
// Scoreboard for the rock-paper-scissors grid automaton: watches the item, result and cfg channels.
// Keeps its own grid and register copies, predicts each result and compares. Needs rpsga_pkg.
`timescale 1ns / 1ps

module tb_rpsga_checker #(
	parameter int GRID_ROWS = 128,
	parameter int GRID_COLS = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_ready,
	input  rpsga_pkg::rpsga_item_t item_data,
	input  logic                  res_valid,
	input  logic                  res_ready,
	input  rpsga_pkg::rpsga_res_t  res_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  rpsga_pkg::rpsga_cfg_t  cfg_data,
	output int                    errors,
	output int                    awaiting
);
	import rpsga_pkg::*;

	localparam int CELLS = GRID_ROWS * GRID_COLS;

	bit [1:0]   board [CELLS];
	bit [1:0]   board_next [CELLS];
	logic [7:0] rows_set;
	logic [7:0] cols_set;
	logic [9:0] gens_set;
	rpsga_res_t replies_due [$];

	function automatic logic [1:0] conqueror(input logic [1:0] v);
		case (v)
			CELL_ROCK:     return CELL_PAPER;
			CELL_PAPER:    return CELL_SCISSORS;
			CELL_SCISSORS: return CELL_ROCK;
			default:       return CELL_INERT;
		endcase
	endfunction

	function automatic void advance_board(input int nr, input int nc, input int gens);
		int here;
		logic [1:0] b;
		bit hit;
		for (int g = 0; g < gens; g++) begin
			for (int x = 0; x < nr; x++) begin
				for (int y = 0; y < nc; y++) begin
					here = x * GRID_COLS + y;
					b = conqueror(board[here]);
					hit = 1'b0;
					if (b != CELL_INERT) begin
						if (x > 0 && board[here - GRID_COLS] == b) hit = 1'b1;
						if (x + 1 < nr && board[here + GRID_COLS] == b) hit = 1'b1;
						if (y > 0 && board[here - 1] == b) hit = 1'b1;
						if (y + 1 < nc && board[here + 1] == b) hit = 1'b1;
					end
					board_next[here] = hit ? b : board[here];
				end
			end
			for (int x = 0; x < nr; x++) begin
				for (int y = 0; y < nc; y++) begin
					board[x * GRID_COLS + y] = board_next[x * GRID_COLS + y];
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rpsga_res_t want;
		rpsga_res_t reply;
		int nr;
		int nc;
		int spot;
		if (!arst_n) begin
			rows_set = 8'd1;
			cols_set = 8'd1;
			gens_set = 10'd0;
			replies_due.delete();
			errors = 0;
			awaiting <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (replies_due.size() == 0) begin
					$error("result beat with nothing expected: cell_res %0d, done_res %0d",
						res_data.cell_res, res_data.done_res);
					errors = errors + 1;
				end else begin
					want = replies_due.pop_front();
					if (res_data.cell_res !== want.cell_res) begin
						$error("cell_res mismatch: expected %0d, actual %0d",
							want.cell_res, res_data.cell_res);
						errors = errors + 1;
					end
					if (res_data.done_res !== want.done_res) begin
						$error("done_res mismatch: expected %0d, actual %0d",
							want.done_res, res_data.done_res);
						errors = errors + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					CFG_ROWS: rows_set = cfg_data.value[7:0];
					CFG_COLS: cols_set = cfg_data.value[7:0];
					CFG_GENS: gens_set = cfg_data.value;
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				reply.cell_res = CELL_ROCK;
				reply.done_res = 1'b1;
				spot = int'(item_data.row) * GRID_COLS + int'(item_data.col);
				case (item_data.mode)
					MODE_WRITE: begin
						if (item_data.row < GRID_ROWS && item_data.col < GRID_COLS)
							board[spot] = item_data.value;
					end
					MODE_RUN: begin
						nr = (rows_set > GRID_ROWS) ? GRID_ROWS : int'(rows_set);
						nc = (cols_set > GRID_COLS) ? GRID_COLS : int'(cols_set);
						if (nr != 0 && nc != 0) advance_board(nr, nc, int'(gens_set));
					end
					MODE_READ: begin
						if (item_data.row < GRID_ROWS && item_data.col < GRID_COLS)
							reply.cell_res = board[spot];
					end
					default: ;
				endcase
				replies_due.push_back(reply);
			end
			awaiting <= replies_due.size();
		end
	end

endmodule

>>> sim/tb_top.sv
// Testbench top for the rock-paper-scissors grid automaton: clock, reset, stimulus and verdict.
// Depends on rpsga_pkg, rpsga_chan_if, rps_grid_automaton_top and tb_rpsga_checker.
`timescale 1ns / 1ps

module tb_top;
	import rpsga_pkg::*;

	localparam int GRID_ROWS = 128;
	localparam int GRID_COLS = 128;
	localparam int CELLS = GRID_ROWS * GRID_COLS;
	localparam logic [1:0] MODE_NOOP = 2'd3;
	localparam int QUIET_LIMIT = 40000;
	localparam int LONG_HOLD = 400;
	localparam int RANDOM_ITEMS = 60;

	logic clk = 1'b0;
	logic arst_n;
	int errors;
	int awaiting;

	bit written [CELLS];
	int written_at [$];
	int items_sent;
	int span_rows;
	int span_cols;
	bit sender_calm;
	bit squeeze_req;
	bit squeeze_done;
	int quiet = 0;

	rpsga_chan_if #(.payload_t(rpsga_item_t)) item_ch ();
	rpsga_chan_if #(.payload_t(rpsga_res_t)) res_ch ();
	rpsga_chan_if #(.payload_t(rpsga_cfg_t)) cfg_ch ();

	rps_grid_automaton_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	tb_rpsga_checker #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_ch.valid),
		.item_ready (item_ch.ready),
		.item_data  (item_ch.data),
		.res_valid  (res_ch.valid),
		.res_ready  (res_ch.ready),
		.res_data   (res_ch.data),
		.cfg_valid  (cfg_ch.valid),
		.cfg_ready  (cfg_ch.ready),
		.cfg_data   (cfg_ch.data),
		.errors     (errors),
		.awaiting   (awaiting)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [1:0] rand_cell();
		if ($urandom_range(0, 99) < 8) return CELL_INERT;
		return 2'($urandom_range(0, 2));
	endfunction

	task automatic send_item(input logic [1:0] mode, input logic [6:0] row,
		input logic [6:0] col, input logic [1:0] value);
		int gap;
		rpsga_item_t beat;
		gap = pick_gap(sender_calm);
		beat.mode = mode;
		beat.row = row;
		beat.col = col;
		beat.value = value;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= beat;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
		if (mode == MODE_WRITE && !written[int'(row) * GRID_COLS + int'(col)]) begin
			written[int'(row) * GRID_COLS + int'(col)] = 1'b1;
			written_at.push_back(int'(row) * GRID_COLS + int'(col));
		end
	endtask

	task automatic read_any();
		int spot;
		spot = written_at[$urandom_range(0, written_at.size() - 1)];
		send_item(MODE_READ, 7'(spot / GRID_COLS), 7'(spot % GRID_COLS),
			2'($urandom_range(0, 3)));
	endtask

	task automatic run_grid();
		send_item(MODE_RUN, 7'($urandom), 7'($urandom), 2'($urandom));
	endtask

	task automatic fill_region();
		for (int x = 0; x < span_rows; x++) begin
			for (int y = 0; y < span_cols; y++) begin
				send_item(MODE_WRITE, 7'(x), 7'(y), rand_cell());
			end
		end
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] nrows, input logic [7:0] ncols,
		input logic [9:0] ngens);
		rpsga_cfg_t writes [3];
		writes[0] = '{index: CFG_ROWS, value: {2'b00, nrows}};
		writes[1] = '{index: CFG_COLS, value: {2'b00, ncols}};
		writes[2] = '{index: CFG_GENS, value: ngens};
		wait_idle();
		for (int i = 0; i < 3; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.data <= writes[i];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
		span_rows = (nrows > GRID_ROWS) ? GRID_ROWS : int'(nrows);
		span_cols = (ncols > GRID_COLS) ? GRID_COLS : int'(ncols);
		sender_calm = ($urandom_range(0, 3) == 0);
	endtask

	initial begin
		int burst;
		int stall;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (squeeze_req && !squeeze_done) begin
				squeeze_done = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				burst = $urandom_range(1, 20);
				res_ch.ready <= 1'b1;
				repeat (burst) @(posedge clk);
				stall = pick_gap($urandom_range(0, 4) == 0);
				if (stall > 0) begin
					res_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		int target;
		int sel;
		int ops;
		int r;
		arst_n = 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		span_rows = 1;
		span_cols = 1;
		sender_calm = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size is one cell with zero generations.
		send_item(MODE_WRITE, 7'd0, 7'd0, CELL_PAPER);
		run_grid();
		send_item(MODE_READ, 7'd0, 7'd0, CELL_ROCK);
		send_item(MODE_NOOP, 7'h7F, 7'h7F, 2'd3);
		send_item(MODE_WRITE, 7'd127, 7'd127, CELL_SCISSORS);
		send_item(MODE_READ, 7'd127, 7'd127, CELL_ROCK);
		send_item(MODE_WRITE, 7'd127, 7'd0, CELL_INERT);
		send_item(MODE_READ, 7'd127, 7'd0, CELL_ROCK);
		send_item(MODE_WRITE, 7'd0, 7'd127, CELL_ROCK);
		send_item(MODE_READ, 7'd0, 7'd127, CELL_INERT);
		send_item(MODE_WRITE, 7'h55, 7'h2A, CELL_PAPER);
		send_item(MODE_READ, 7'h55, 7'h2A, CELL_ROCK);

		// A 3x3 grid holding all three kinds and an inert cell in the middle.
		configure(8'd3, 8'd3, 10'd1);
		send_item(MODE_WRITE, 7'd0, 7'd0, CELL_ROCK);
		send_item(MODE_WRITE, 7'd0, 7'd1, CELL_PAPER);
		send_item(MODE_WRITE, 7'd0, 7'd2, CELL_SCISSORS);
		send_item(MODE_WRITE, 7'd1, 7'd0, CELL_SCISSORS);
		send_item(MODE_WRITE, 7'd1, 7'd1, CELL_INERT);
		send_item(MODE_WRITE, 7'd1, 7'd2, CELL_ROCK);
		send_item(MODE_WRITE, 7'd2, 7'd0, CELL_PAPER);
		send_item(MODE_WRITE, 7'd2, 7'd1, CELL_ROCK);
		send_item(MODE_WRITE, 7'd2, 7'd2, CELL_SCISSORS);
		run_grid();
		send_item(MODE_READ, 7'd0, 7'd0, CELL_ROCK);
		send_item(MODE_READ, 7'd1, 7'd1, CELL_ROCK);
		send_item(MODE_READ, 7'd2, 7'd1, CELL_ROCK);

		configure(8'd2, 8'd2, 10'd1023);
		fill_region();
		run_grid();
		for (int i = 0; i < 4; i++) send_item(MODE_READ, 7'(i / 2), 7'(i % 2), 2'd0);

		configure(8'd0, 8'd5, 10'd3);
		run_grid();
		read_any();
		configure(8'd5, 8'd0, 10'd3);
		run_grid();
		read_any();

		squeeze_req = 1'b1;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			sel = $urandom_range(0, 99);
			if (sel < 3)
				configure(8'd0, 8'($urandom_range(1, 5)), 10'($urandom_range(0, 12)));
			else if (sel < 6)
				configure(8'($urandom_range(1, 5)), 8'd0, 10'($urandom_range(0, 12)));
			else if (sel < 14)
				configure(8'($urandom_range(1, 2)), 8'($urandom_range(1, 2)), 10'd1023);
			else
				configure(8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)),
					10'($urandom_range(0, 12)));
			fill_region();
			ops = $urandom_range(10, 16);
			for (int i = 0; i < ops; i++) begin
				r = $urandom_range(0, 99);
				if (r < 18)
					send_item(MODE_WRITE, 7'($urandom), 7'($urandom), rand_cell());
				else if (r < 35)
					send_item(MODE_WRITE, 7'($urandom_range(0, span_rows > 0 ? span_rows - 1 : 0)),
						7'($urandom_range(0, span_cols > 0 ? span_cols - 1 : 0)), rand_cell());
				else if (r < 65)
					read_any();
				else if (r < 88)
					run_grid();
				else
					send_item(MODE_NOOP, 7'($urandom), 7'($urandom), 2'($urandom));
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0 && awaiting == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
design/rpsga_pkg.sv
design/rpsga_chan_if.sv
design/rpsga_ram.sv
design/rpsga_upd.sv
design/rpsga_ctrl.sv
design/rps_grid_automaton_top.sv
design/rpsga_chk.sv
sim/tb_rpsga_checker.sv
sim/tb_top.sv
